[design/scaled_sprite_shadow_compositor_top_macros.svh]
// Assertion macros for the scaled sprite compositor.
// Used by scaled_sprite_shadow_compositor_top; no other dependencies.
`ifndef SCALED_SPRITE_SHADOW_COMPOSITOR_TOP_MACROS_SVH
`define SCALED_SPRITE_SHADOW_COMPOSITOR_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define SSSC_ASSERT_IMP(lbl, clk_i, rstn, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("compositor same-cycle check failed");
// Next-cycle implication, disabled while in reset.
`define SSSC_ASSERT_NXT(lbl, clk_i, rstn, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("compositor next-cycle check failed");
`else
`define SSSC_ASSERT_IMP(lbl, clk_i, rstn, ante, cons)
`define SSSC_ASSERT_NXT(lbl, clk_i, rstn, ante, cons)
`endif

`endif

[design/sssc_pkg.sv]
// Package for the scaled sprite compositor: sizes, register codes, tables.
// No dependencies; imported by scaled_sprite_shadow_compositor_top.
`default_nettype none

package sssc_pkg;

	// Sprite and screen limits.
	localparam int MAX_SPRITE_W = 64;
	localparam int MAX_SPRITE_H = 64;
	localparam int MAX_SCALE    = 8;
	localparam int SCREEN_W     = 320;
	localparam int SCREEN_H     = 240;
	localparam int ROW_AW       = $clog2(MAX_SPRITE_H);

	// Field widths.
	localparam int COLOR_W = 32;
	localparam int ROW_W   = 64;
	localparam int COORD_W = 10;
	localparam int POS_W   = 11;
	localparam int CFG_IW  = 3;

	// Item operation codes carried on func.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IW-1:0] {
		CFG_SPRITE_X      = 3'd0,
		CFG_SPRITE_Y      = 3'd1,
		CFG_SPRITE_WIDTH  = 3'd2,
		CFG_SPRITE_HEIGHT = 3'd3,
		CFG_SCALE_FACTOR  = 3'd4,
		CFG_INK_COLOR     = 3'd5,
		CFG_SHADOW_ENABLE = 3'd6
	} cfg_reg_t;

	// Reciprocal ceil(2^16 / d) for the scale factors; exact floor division
	// for numerators below 512.
	function automatic logic [16:0] scale_recip(input logic [3:0] d);
		logic [16:0] m;
		case (d)
			4'd1:    m = 17'd65536;
			4'd2:    m = 17'd32768;
			4'd3:    m = 17'd21846;
			4'd4:    m = 17'd16384;
			4'd5:    m = 17'd13108;
			4'd6:    m = 17'd10923;
			4'd7:    m = 17'd9363;
			4'd8:    m = 17'd8192;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

	// floor(v * 2 / 3) for one 8-bit channel, by multiplying with 171/512.
	function automatic logic [7:0] two_thirds(input logic [7:0] v);
		logic [16:0] t;
		t = 17'({v, 1'b0}) * 17'd171;
		return t[16:9];
	endfunction

	// Shadow color: each channel at two thirds, alpha opaque.
	function automatic logic [COLOR_W-1:0] darken(input logic [COLOR_W-1:0] c);
		return {8'hFF, two_thirds(c[23:16]), two_thirds(c[15:8]), two_thirds(c[7:0])};
	endfunction

endpackage

`default_nettype wire

[design/scaled_sprite_shadow_compositor_top.sv]
// Scaled one-bit sprite compositor with elliptical drop shadow, top level.
// Depends on sssc_pkg and scaled_sprite_shadow_compositor_top_macros.svh.
//
// The block takes one item per clock, load or composite, and a composite item
// gives its result from the stage 6 output register; a load item gives none.
// The rate is set by a six-deep register pipeline with per-stage valid bits,
// so an item enters every cycle as long as the output is taken. The sprite
// rows live in a 64 x 64 bit RAM with one write and one registered read port,
// both used at the third stage, so a row loaded by an earlier item is seen by
// every later pixel. The RAM has no reset and no clearing pass: only rows that
// have been loaded may be hit. Configuration writes are taken at any time
// (cfg_ready stays high) but must only be issued while the pipeline is empty.
`default_nettype none
`include "scaled_sprite_shadow_compositor_top_macros.svh"

module scaled_sprite_shadow_compositor_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Configuration write channel
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [sssc_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [31:0]                  cfg_data,
	// Input item channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         func,
	input  wire logic [5:0]                   row_index,
	input  wire logic [sssc_pkg::ROW_W-1:0]   row_bits,
	input  wire logic [sssc_pkg::COORD_W-1:0] pixel_x,
	input  wire logic [sssc_pkg::COORD_W-1:0] pixel_y,
	input  wire logic [sssc_pkg::COLOR_W-1:0] pixel_color,
	// Result item channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [sssc_pkg::COLOR_W-1:0]      out_color,
	output logic                              hit_sprite,
	output logic                              hit_shadow
);
	import sssc_pkg::*;

	// Configuration registers
	logic [POS_W-1:0]   sprite_x_q, sprite_y_q;
	logic [6:0]         width_q, height_q;
	logic [3:0]         scale_q;
	logic [COLOR_W-1:0] ink_q;
	logic               shen_q;
	logic [3:0]         scale_wr;

	// Stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy2, rdy3, rdy4, rdy5, rdy6;

	// Stage 1
	logic               func_s1;
	logic [5:0]         row_index_s1;
	logic [ROW_W-1:0]   row_bits_s1;
	logic [COORD_W-1:0] px_s1, py_s1;
	logic [COLOR_W-1:0] color_s1;
	logic [6:0]         w1, h1;
	logic [10:0]        swp1, shp1;
	logic signed [12:0] sx1, sy1;
	logic               onscr1;

	// Stage 2
	logic               func_s2;
	logic [5:0]         row_index_s2;
	logic [ROW_W-1:0]   row_bits_s2;
	logic [COLOR_W-1:0] color_s2;
	logic               onscr_s2;
	logic signed [12:0] sx_s2, sy_s2;
	logic [9:0]         sw_s2, sh_s2;
	logic               inbox2;
	logic [8:0]         rx2;
	logic [16:0]        rxm2;
	logic [6:0]         ry2;
	logic signed [12:0] dx2, dy2;
	logic [16:0]        recip2;
	logic [25:0]        colp2, rowp2;

	// Stage 3
	logic               func_s3;
	logic [5:0]         row_index_s3;
	logic [ROW_W-1:0]   row_bits_s3;
	logic [COLOR_W-1:0] color_s3;
	logic               onscr_s3, inbox_s3;
	logic [5:0]         col_s3, row_s3;
	logic [8:0]         rx_s3;
	logic [6:0]         ry_s3;
	logic signed [12:0] dx_s3, dy_s3;
	logic [12:0]        ax3, ay3;
	logic               inb3;
	logic [15:0]        ap3, bp3, cp3;

	// Stage 4
	logic [COLOR_W-1:0] color_s4;
	logic               onscr_s4, inbox_s4, inb_s4;
	logic [5:0]         col_s4;
	logic [ROW_W-1:0]   rdata_s4;
	logic [14:0]        a_s4, b_s4, c_s4;
	logic               hs4;

	// Stage 5
	logic [COLOR_W-1:0] color_s5;
	logic               onscr_s5, hs_s5, inb_s5;
	logic [29:0]        aa_s5, bb_s5, cc_s5;
	logic               hd5;
	logic [COLOR_W-1:0] res5;

	// Stage 6: output register
	logic [COLOR_W-1:0] color_s6;
	logic               hs_s6, hd_s6;

	// Sprite row RAM
	logic [ROW_W-1:0] rows_q [MAX_SPRITE_H];

	// Configuration port, always ready; the scale is clamped on write.
	assign cfg_ready = 1'b1;

	always_comb begin
		scale_wr = cfg_data[3:0];
		if (scale_wr == 4'd0) begin
			scale_wr = 4'd1;
		end else if (scale_wr > 4'(MAX_SCALE)) begin
			scale_wr = 4'(MAX_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_x_q <= '0;
			sprite_y_q <= '0;
			width_q    <= 7'd1;
			height_q   <= 7'd1;
			scale_q    <= 4'd1;
			ink_q      <= '0;
			shen_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SPRITE_X:      sprite_x_q <= cfg_data[POS_W-1:0];
				CFG_SPRITE_Y:      sprite_y_q <= cfg_data[POS_W-1:0];
				CFG_SPRITE_WIDTH:  width_q    <= cfg_data[6:0];
				CFG_SPRITE_HEIGHT: height_q   <= cfg_data[6:0];
				CFG_SCALE_FACTOR:  scale_q    <= scale_wr;
				CFG_INK_COLOR:     ink_q      <= cfg_data;
				CFG_SHADOW_ENABLE: shen_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Ready chain: a stage takes new data when empty or when it moves on.
	assign rdy6     = !v_s6 || out_ready;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign in_ready = !v_s1 || rdy2;

	// Valid bits; load items leave the pipeline after the RAM stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (rdy2)     v_s2 <= v_s1;
			if (rdy3)     v_s3 <= v_s2;
			if (rdy4)     v_s4 <= v_s3 && func_s3;
			if (rdy5)     v_s5 <= v_s4;
			if (rdy6)     v_s6 <= v_s5;
		end
	end

	// Stage 1 capture.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1      <= func;
			row_index_s1 <= row_index;
			row_bits_s1  <= row_bits;
			px_s1        <= pixel_x;
			py_s1        <= pixel_y;
			color_s1     <= pixel_color;
		end
	end

	// Stage 1 logic: scaled sprite size, offsets from the sprite corner, on-screen test.
	always_comb begin
		w1     = (width_q > 7'(MAX_SPRITE_W)) ? 7'(MAX_SPRITE_W) : width_q;
		h1     = (height_q > 7'(MAX_SPRITE_H)) ? 7'(MAX_SPRITE_H) : height_q;
		swp1   = 11'(w1) * 11'(scale_q);
		shp1   = 11'(h1) * 11'(scale_q);
		sx1    = $signed({3'b000, px_s1}) - $signed({{2{sprite_x_q[POS_W-1]}}, sprite_x_q});
		sy1    = $signed({3'b000, py_s1}) - $signed({{2{sprite_y_q[POS_W-1]}}, sprite_y_q});
		onscr1 = ({1'b0, px_s1} < 11'(SCREEN_W)) && ({1'b0, py_s1} < 11'(SCREEN_H));
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			func_s2      <= func_s1;
			row_index_s2 <= row_index_s1;
			row_bits_s2  <= row_bits_s1;
			color_s2     <= color_s1;
			onscr_s2     <= onscr1;
			sx_s2        <= sx1;
			sy_s2        <= sy1;
			sw_s2        <= swp1[9:0];
			sh_s2        <= shp1[9:0];
		end
	end

	// Stage 2 logic: box test, sprite cell by reciprocal multiply, shadow radii.
	always_comb begin
		inbox2 = !sx_s2[12] && !sy_s2[12] &&
			(sx_s2[11:0] < {2'b00, sw_s2}) && (sy_s2[11:0] < {2'b00, sh_s2});
		recip2 = scale_recip(scale_q);
		colp2  = 26'(sx_s2[8:0]) * 26'(recip2);
		rowp2  = 26'(sy_s2[8:0]) * 26'(recip2);
		rx2    = sw_s2[9:1];
		rxm2   = 17'(rx2) * 17'd171;
		ry2    = (rx2 > 9'd2) ? rxm2[15:9] : 7'd1;
		dx2    = sx_s2 - $signed({4'b0000, rx2});
		dy2    = sy_s2 - $signed({3'b000, sh_s2});
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			func_s3      <= func_s2;
			row_index_s3 <= row_index_s2;
			row_bits_s3  <= row_bits_s2;
			color_s3     <= color_s2;
			onscr_s3     <= onscr_s2;
			inbox_s3     <= inbox2;
			col_s3       <= colp2[21:16];
			row_s3       <= rowp2[21:16];
			rx_s3        <= rx2;
			ry_s3        <= ry2;
			dx_s3        <= dx2;
			dy_s3        <= dy2;
		end
	end

	// Sprite RAM: loads write and pixels read at the same stage, in item order.
	always_ff @(posedge clk) begin
		if (rdy4 && v_s3 && !func_s3 && ({1'b0, row_index_s3} < 7'(MAX_SPRITE_H))) begin
			rows_q[row_index_s3[ROW_AW-1:0]] <= row_bits_s3;
		end
		if (rdy4 && v_s3 && func_s3) begin
			rdata_s4 <= rows_q[row_s3[ROW_AW-1:0]];
		end
	end

	// Stage 3 logic: ellipse bounding box and scaled terms of the ellipse test.
	always_comb begin
		ax3 = dx_s3[12] ? 13'(-dx_s3) : 13'(dx_s3);
		ay3 = dy_s3[12] ? 13'(-dy_s3) : 13'(dy_s3);
		inb3 = (ax3 <= {4'b0000, rx_s3}) && (ay3 <= {6'b000000, ry_s3});
		ap3 = 16'(ax3[8:0]) * 16'(ry_s3);
		bp3 = 16'(ay3[6:0]) * 16'(rx_s3);
		cp3 = 16'(rx_s3) * 16'(ry_s3);
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3 && func_s3) begin
			color_s4 <= color_s3;
			onscr_s4 <= onscr_s3;
			inbox_s4 <= inbox_s3;
			col_s4   <= col_s3;
			inb_s4   <= inb3;
			a_s4     <= ap3[14:0];
			b_s4     <= bp3[14:0];
			c_s4     <= cp3[14:0];
		end
	end

	// Stage 4 logic: sprite bit lookup.
	assign hs4 = onscr_s4 && inbox_s4 && rdata_s4[col_s4];

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			color_s5 <= color_s4;
			onscr_s5 <= onscr_s4;
			hs_s5    <= hs4;
			inb_s5   <= inb_s4;
			aa_s5    <= 30'(a_s4) * 30'(a_s4);
			bb_s5    <= 30'(b_s4) * 30'(b_s4);
			cc_s5    <= 30'(c_s4) * 30'(c_s4);
		end
	end

	// Stage 5 logic: ellipse compare and color select; the sprite wins.
	always_comb begin
		hd5 = onscr_s5 && shen_q && !hs_s5 && inb_s5 &&
			((31'(aa_s5) + 31'(bb_s5)) <= 31'(cc_s5));
		if (hs_s5) begin
			res5 = ink_q;
		end else if (hd5) begin
			res5 = darken(color_s5);
		end else begin
			res5 = color_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			color_s6 <= res5;
			hs_s6    <= hs_s5;
			hd_s6    <= hd5;
		end
	end

	assign out_valid  = v_s6;
	assign out_color  = color_s6;
	assign hit_sprite = hs_s6;
	assign hit_shadow = hd_s6;

	// Checks on the result path and the stall logic.
	`SSSC_ASSERT_IMP(a_flags_exclusive, clk, arst_n, out_valid, !(hit_sprite && hit_shadow))
	`SSSC_ASSERT_IMP(a_sprite_is_ink, clk, arst_n, out_valid && hit_sprite, out_color == ink_q)
	`SSSC_ASSERT_IMP(a_shadow_opaque, clk, arst_n, out_valid && hit_shadow, shen_q && (out_color[31:24] == 8'hFF))
	`SSSC_ASSERT_NXT(a_stall_holds_s5, clk, arst_n, v_s5 && !rdy6, v_s5 && $stable(color_s5))

endmodule

`default_nettype wire
